// File: sv/bod_pkg.sv
// bod_pkg: shared types and constants for the byte offset decoder
// used by the front, queue, back and top level files; depends on nothing

package bod_pkg;

    // escape tracking of the compressed byte stream
    typedef enum logic [2:0] {
        ST_SHORT  = 3'd0,
        ST_W16_LO = 3'd1,
        ST_W16_HI = 3'd2,
        ST_W32_B0 = 3'd3,
        ST_W32_B1 = 3'd4,
        ST_W32_B2 = 3'd5,
        ST_W32_B3 = 3'd6
    } t_stage;

    // configuration register select, taken from paddr bit 2
    typedef enum logic {
        REG_ROWS = 1'b0,
        REG_COLS = 1'b1
    } t_reg_idx;

    localparam int          PADDR_W   = 3;
    localparam int          REG_W     = 15;
    localparam int          DELTA_W   = 32;
    localparam logic [7:0]  ESC_BYTE  = 8'h80;
    localparam logic [15:0] ESC_WORD  = 16'h8000;

    // delta queue geometry (depth is a power of two, pointers wrap)
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    // one finished delta moving from front to back
    typedef struct packed {
        logic               valid;
        logic [DELTA_W-1:0] delta;
    } t_delta_item;

endpackage

// File: sv/byte_offset_decoder_core.sv
// byte offset decoder: one compressed byte per cycle in, one 32-bit pixel per delta out
// a completed delta passes the delta queue, then the output register, to the master side
// throughput: one byte per cycle sustained; stalls only when the 4-entry delta queue is full
// an escape byte or a byte inside a wide delta produces no pixel
// reset: synchronous, active low; rows and columns return to 1, state to zero
// depends on bod_pkg, bod_front, bod_queue, bod_back

module byte_offset_decoder_core #(
    parameter int MAX_SIDE = 16384
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input stream, one compressed byte per transfer
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  logic [7:0]                  i_s_axis_tdata,   // [7:0] data_byte
    // pixel stream
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    output logic [31:0]                 o_m_axis_tdata,   // [31:0] pixel_value
    output logic                        o_m_axis_tlast,   // last_pixel
    // register port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bod_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    // side and frame size widths follow the largest allowed side
    localparam int              SIDE_W     = $clog2(MAX_SIDE + 1);
    localparam int              TOT_W      = 2 * SIDE_W;
    localparam logic [SIDE_W-1:0] MAX_SIDE_V = SIDE_W'(MAX_SIDE);

    logic [bod_pkg::REG_W-1:0] r_rows, r_cols;
    logic [SIDE_W-1:0]         rows_c, cols_c;
    logic [TOT_W-1:0]          r_total;
    logic                      cfg_wr;
    bod_pkg::t_reg_idx         reg_sel;

    bod_pkg::t_delta_item      push_item, head_item;
    logic                      q_ready, pop;

    // ------------------------------------------------------------------
    // register port: two registers, selected by paddr bit 2
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign reg_sel = bod_pkg::t_reg_idx'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_comb begin
        unique case (reg_sel)
            bod_pkg::REG_ROWS: prdata = {17'd0, r_rows};
            bod_pkg::REG_COLS: prdata = {17'd0, r_cols};
            default:           prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= bod_pkg::REG_W'(1);
            r_cols <= bod_pkg::REG_W'(1);
        end else if (cfg_wr) begin
            if (reg_sel == bod_pkg::REG_ROWS) begin
                r_rows <= pwdata[bod_pkg::REG_W-1:0];
            end else begin
                r_cols <= pwdata[bod_pkg::REG_W-1:0];
            end
        end
    end

    // a zero side counts as one, an oversize side as the maximum
    always_comb begin
        if (r_rows == '0) begin
            rows_c = SIDE_W'(1);
        end else if (32'(r_rows) > 32'(MAX_SIDE)) begin
            rows_c = MAX_SIDE_V;
        end else begin
            rows_c = SIDE_W'(r_rows);
        end
        if (r_cols == '0) begin
            cols_c = SIDE_W'(1);
        end else if (32'(r_cols) > 32'(MAX_SIDE)) begin
            cols_c = MAX_SIDE_V;
        end else begin
            cols_c = SIDE_W'(r_cols);
        end
    end

    // pixels per frame, registered from the clamped row and column registers
    always_ff @(posedge i_clk) begin
        r_total <= TOT_W'(rows_c) * TOT_W'(cols_c);
    end

    // ------------------------------------------------------------------
    // front: escape sequencer, turns bytes into finished deltas
    // ------------------------------------------------------------------
    bod_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_axis_tvalid),
        .i_byte    (i_s_axis_tdata),
        .i_q_ready (q_ready),
        .o_ready   (o_s_axis_tready),
        .o_push    (push_item)
    );

    // short queue so a stalled pixel consumer does not stop the byte side at once
    bod_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push_item),
        .i_pop   (pop),
        .o_ready (q_ready),
        .o_head  (head_item)
    );

    // back: running sum, frame count, output register
    bod_back #(
        .TOT_W (TOT_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head_item),
        .i_total     (r_total),
        .i_out_ready (i_m_axis_tready),
        .o_pop       (pop),
        .o_valid     (o_m_axis_tvalid),
        .o_pixel     (o_m_axis_tdata),
        .o_last      (o_m_axis_tlast)
    );

endmodule

// File: sv/bod_front.sv
// bod_front: byte classifier and escape sequencer of the byte offset decoder
// depends on bod_pkg; feeds finished deltas into bod_queue

module bod_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic [7:0]                i_byte,
    input  logic                      i_q_ready,
    output logic                      o_ready,
    output bod_pkg::t_delta_item      o_push
);

    bod_pkg::t_stage r_stage, n_stage;
    logic [23:0]     r_gather, n_gather;
    logic            accept;
    logic [15:0]     word16;

    assign o_ready = i_q_ready;
    assign accept  = i_valid && i_q_ready;
    assign word16  = {i_byte, r_gather[7:0]};

    // next state
    always_comb begin
        n_stage  = r_stage;
        n_gather = r_gather;
        if (accept) begin
            unique case (r_stage)
                bod_pkg::ST_W16_LO: begin
                    n_gather = {16'd0, i_byte};
                    n_stage  = bod_pkg::ST_W16_HI;
                end
                bod_pkg::ST_W16_HI: begin
                    n_gather = 24'd0;
                    n_stage  = (word16 == bod_pkg::ESC_WORD) ? bod_pkg::ST_W32_B0
                                                              : bod_pkg::ST_SHORT;
                end
                bod_pkg::ST_W32_B0: begin
                    n_gather = {16'd0, i_byte};
                    n_stage  = bod_pkg::ST_W32_B1;
                end
                bod_pkg::ST_W32_B1: begin
                    n_gather[15:8] = i_byte;
                    n_stage        = bod_pkg::ST_W32_B2;
                end
                bod_pkg::ST_W32_B2: begin
                    n_gather[23:16] = i_byte;
                    n_stage         = bod_pkg::ST_W32_B3;
                end
                bod_pkg::ST_W32_B3: begin
                    n_gather = 24'd0;
                    n_stage  = bod_pkg::ST_SHORT;
                end
                default: begin
                    n_gather = 24'd0;
                    n_stage  = (i_byte == bod_pkg::ESC_BYTE) ? bod_pkg::ST_W16_LO
                                                              : bod_pkg::ST_SHORT;
                end
            endcase
        end
    end

    // outputs: push a delta when a byte completes one
    always_comb begin
        o_push.valid = 1'b0;
        o_push.delta = {{24{i_byte[7]}}, i_byte};
        unique case (r_stage)
            bod_pkg::ST_W16_LO, bod_pkg::ST_W32_B0,
            bod_pkg::ST_W32_B1, bod_pkg::ST_W32_B2: begin
                o_push.valid = 1'b0;
            end
            bod_pkg::ST_W16_HI: begin
                o_push.valid = accept && (word16 != bod_pkg::ESC_WORD);
                o_push.delta = {{16{word16[15]}}, word16};
            end
            bod_pkg::ST_W32_B3: begin
                o_push.valid = accept;
                o_push.delta = {i_byte, r_gather};
            end
            default: begin
                o_push.valid = accept && (i_byte != bod_pkg::ESC_BYTE);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage  <= bod_pkg::ST_SHORT;
            r_gather <= 24'd0;
        end else begin
            r_stage  <= n_stage;
            r_gather <= n_gather;
        end
    end

endmodule

// File: sv/bod_queue.sv
// bod_queue: short delta queue between front and back
// depends on bod_pkg; register based, depth from the package

module bod_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  bod_pkg::t_delta_item  i_push,
    input  logic                  i_pop,
    output logic                  o_ready,
    output bod_pkg::t_delta_item  o_head
);

    logic [bod_pkg::DELTA_W-1:0] r_mem [bod_pkg::Q_DEPTH];
    logic [bod_pkg::Q_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [bod_pkg::Q_CNT_W-1:0] r_count;
    logic                        do_push, do_pop;

    assign o_ready      = (r_count != bod_pkg::Q_CNT_W'(bod_pkg::Q_DEPTH));
    assign do_push      = i_push.valid && o_ready;
    assign do_pop       = i_pop && (r_count != '0);
    assign o_head.valid = (r_count != '0);
    assign o_head.delta = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push.delta;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// File: sv/bod_back.sv
// bod_back: pixel accumulator, frame counter and output register
// depends on bod_pkg; takes deltas from bod_queue

module bod_back #(
    parameter int TOT_W = 30
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  bod_pkg::t_delta_item        i_head,
    input  logic [TOT_W-1:0]            i_total,
    input  logic                        i_out_ready,
    output logic                        o_pop,
    output logic                        o_valid,
    output logic [bod_pkg::DELTA_W-1:0] o_pixel,
    output logic                        o_last
);

    logic [bod_pkg::DELTA_W-1:0] r_acc, r_pixel, sum;
    logic [TOT_W-1:0]            r_cnt, cnt_inc;
    logic                        r_valid, r_last, frame_end;

    assign o_pop     = i_head.valid && (!r_valid || i_out_ready);
    assign sum       = r_acc + i_head.delta;
    assign cnt_inc   = r_cnt + 1'b1;
    assign frame_end = (cnt_inc >= i_total);

    assign o_valid = r_valid;
    assign o_pixel = r_pixel;
    assign o_last  = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_acc   <= '0;
            r_cnt   <= '0;
        end else begin
            if (o_pop) begin
                r_valid <= 1'b1;
                r_acc   <= frame_end ? '0 : sum;
                r_cnt   <= frame_end ? '0 : cnt_inc;
            end else if (i_out_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_pixel <= sum;
            r_last  <= frame_end;
        end
    end

endmodule

// File: sv/bod_checker.sv
// bod_checker: port level assertions for byte_offset_decoder_core
// depends on no package; attached to the top level by the bind below

module bod_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_axis_tvalid,
    input  logic                        o_s_axis_tready,
    input  logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    input  logic [31:0]                 o_m_axis_tdata,
    input  logic                        o_m_axis_tlast,
    input  logic                        pready
);

    // register port never waits
    a_pready_high: assert property (@(posedge i_clk) pready)
        else $error("pready low");

    // reset empties the output register
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_axis_tvalid)
        else $error("pixel valid after reset");

    // queue can only fill up through an accepted byte
    a_ready_fall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_s_axis_tready) |-> $past(i_s_axis_tvalid))
        else $error("input ready dropped without a transfer");

    // stalled pixel holds valid and payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("stalled pixel changed");

endmodule

bind byte_offset_decoder_core bod_checker u_bod_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast),
    .pready          (pready)
);
